### hw/rtl/irpdt_pkg.sv
// ----------------------------------------------------------------------------
// irpdt_pkg
// Shared types and constants for the infrared pulse-distance transmitter.
// ----------------------------------------------------------------------------
package irpdt_pkg;

  // sizing
  localparam int MAX_CODE_BITS = 64;
  localparam int TIME_WIDTH    = 20;
  localparam int BITS_LEFT_W   = $clog2(MAX_CODE_BITS + 1);

  // fixed field widths
  localparam int CODE_BITS_W = 64;
  localparam int CODE_LEN_W  = 7;
  localparam int SEG_W       = 16;
  localparam int CARR_W      = 7;
  localparam int CPOS_W      = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_IDX_W   = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_ON   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_OFF  = 3'd6;

  // register reset values
  localparam logic [SEG_W-1:0]  RST_LEADER_MARK  = 16'd9000;
  localparam logic [SEG_W-1:0]  RST_LEADER_SPACE = 16'd4500;
  localparam logic [SEG_W-1:0]  RST_BIT_MARK     = 16'd560;
  localparam logic [SEG_W-1:0]  RST_ZERO_SPACE   = 16'd560;
  localparam logic [SEG_W-1:0]  RST_ONE_SPACE    = 16'd1680;
  localparam logic [CARR_W-1:0] RST_CARRIER_ON   = 7'd9;
  localparam logic [CARR_W-1:0] RST_CARRIER_OFF  = 7'd17;

  // input command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_FINAL_MARK = 3'd5
  } phase_t;

  typedef struct packed {
    logic [SEG_W-1:0]  leader_mark_us;
    logic [SEG_W-1:0]  leader_space_us;
    logic [SEG_W-1:0]  bit_mark_us;
    logic [SEG_W-1:0]  zero_space_us;
    logic [SEG_W-1:0]  one_space_us;
    logic [CARR_W-1:0] carrier_on_us;
    logic [CARR_W-1:0] carrier_off_us;
  } cfg_t;

  typedef struct packed {
    logic                   cmd;
    logic [CODE_BITS_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0]  code_length;
  } item_t;

  typedef struct packed {
    logic led;
    logic busy_res;
    logic start_taken;
    logic frame_done;
  } res_t;

  typedef struct packed {
    logic busy;
    logic settled;
  } core_stat_t;

endpackage

### hw/rtl/irpdt_ifs.sv
// ----------------------------------------------------------------------------
// irpdt channel interfaces
// Valid/ready channels for command items and for per-item results.
// ----------------------------------------------------------------------------
interface irpdt_in_if;
  import irpdt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [CODE_BITS_W-1:0] code_bits;
  logic [CODE_LEN_W-1:0]  code_length;

  modport source (output valid, output cmd, output code_bits, output code_length,
                  input ready);
  modport sink   (input valid, input cmd, input code_bits, input code_length,
                  output ready);
endinterface

interface irpdt_out_if;
  logic valid;
  logic ready;
  logic led;
  logic busy_res;
  logic start_taken;
  logic frame_done;

  modport source (output valid, output led, output busy_res, output start_taken,
                  output frame_done, input ready);
  modport sink   (input valid, input led, input busy_res, input start_taken,
                  input frame_done, output ready);
endinterface

### hw/rtl/irpdt_cfg_regs.sv
// ----------------------------------------------------------------------------
// irpdt_cfg_regs
// APB-style register file holding the frame timing and carrier settings.
// ----------------------------------------------------------------------------
module irpdt_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [irpdt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [irpdt_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [irpdt_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output irpdt_pkg::cfg_t                     cfg
);
  import irpdt_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_mark_us  <= RST_LEADER_MARK;
      cfg_r.leader_space_us <= RST_LEADER_SPACE;
      cfg_r.bit_mark_us     <= RST_BIT_MARK;
      cfg_r.zero_space_us   <= RST_ZERO_SPACE;
      cfg_r.one_space_us    <= RST_ONE_SPACE;
      cfg_r.carrier_on_us   <= RST_CARRIER_ON;
      cfg_r.carrier_off_us  <= RST_CARRIER_OFF;
    end else if (wr_en) begin
      case (idx)
        REG_LEADER_MARK:  cfg_r.leader_mark_us  <= pwdata[SEG_W-1:0];
        REG_LEADER_SPACE: cfg_r.leader_space_us <= pwdata[SEG_W-1:0];
        REG_BIT_MARK:     cfg_r.bit_mark_us     <= pwdata[SEG_W-1:0];
        REG_ZERO_SPACE:   cfg_r.zero_space_us   <= pwdata[SEG_W-1:0];
        REG_ONE_SPACE:    cfg_r.one_space_us    <= pwdata[SEG_W-1:0];
        REG_CARRIER_ON:   cfg_r.carrier_on_us   <= pwdata[CARR_W-1:0];
        REG_CARRIER_OFF:  cfg_r.carrier_off_us  <= pwdata[CARR_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    case (idx)
      REG_LEADER_MARK:  prdata = CFG_DATA_W'(cfg_r.leader_mark_us);
      REG_LEADER_SPACE: prdata = CFG_DATA_W'(cfg_r.leader_space_us);
      REG_BIT_MARK:     prdata = CFG_DATA_W'(cfg_r.bit_mark_us);
      REG_ZERO_SPACE:   prdata = CFG_DATA_W'(cfg_r.zero_space_us);
      REG_ONE_SPACE:    prdata = CFG_DATA_W'(cfg_r.one_space_us);
      REG_CARRIER_ON:   prdata = CFG_DATA_W'(cfg_r.carrier_on_us);
      REG_CARRIER_OFF:  prdata = CFG_DATA_W'(cfg_r.carrier_off_us);
      default:          prdata = '0;
    endcase
  end

endmodule

### hw/rtl/irpdt_core.sv
// ----------------------------------------------------------------------------
// irpdt_core
// Frame sequencer: phase, segment timing, carrier position and code shifter.
// ----------------------------------------------------------------------------
module irpdt_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  irpdt_pkg::cfg_t       cfg,
  input  logic                  accept,
  input  irpdt_pkg::item_t      item,
  output irpdt_pkg::res_t       res,
  output irpdt_pkg::core_stat_t stat
);
  import irpdt_pkg::*;

  phase_t                   phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0]    elapsed_r, elapsed_nxt;
  logic [TIME_WIDTH-1:0]    ideal_r, ideal_nxt;
  logic [CPOS_W-1:0]        cpos_r, cpos_nxt;
  logic [MAX_CODE_BITS-1:0] shift_r, shift_nxt;
  logic [BITS_LEFT_W-1:0]   bits_left_r, bits_left_nxt;
  logic                     cur_bit_r, cur_bit_nxt;

  logic                     in_mark, in_space, time_up, pending;
  logic [TIME_WIDTH-1:0]    elapsed_inc, elapsed_sub;
  logic [CPOS_W-1:0]        period, cpos_inc;
  logic [CODE_LEN_W-1:0]    len_sat;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      ideal_r     <= '0;
      cpos_r      <= '0;
      shift_r     <= '0;
      bits_left_r <= '0;
      cur_bit_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      ideal_r     <= ideal_nxt;
      cpos_r      <= cpos_nxt;
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      cur_bit_r   <= cur_bit_nxt;
    end
  end

  // segment status
  assign in_mark     = (phase_r == PH_LEAD_MARK) || (phase_r == PH_BIT_MARK) ||
                       (phase_r == PH_FINAL_MARK);
  assign in_space    = (phase_r == PH_LEAD_SPACE) || (phase_r == PH_BIT_SPACE);
  assign time_up     = (elapsed_r >= ideal_r);
  assign elapsed_inc = elapsed_r + TIME_WIDTH'(1);
  assign elapsed_sub = elapsed_r - ideal_r;
  assign period      = CPOS_W'(cfg.carrier_on_us) + CPOS_W'(cfg.carrier_off_us);
  assign cpos_inc    = cpos_r + CPOS_W'(1);
  assign len_sat     = (item.code_length > CODE_LEN_W'(MAX_CODE_BITS)) ?
                       CODE_LEN_W'(MAX_CODE_BITS) : item.code_length;

  // a segment boundary still to be crossed; the end of the final mark is
  // left for the next tick since it reports the frame end
  assign pending = (((phase_r == PH_LEAD_MARK) || (phase_r == PH_BIT_MARK)) &&
                    (cpos_r == '0) && time_up) || (in_space && time_up);

  // busy, then settled
  assign stat = {(phase_r != PH_IDLE), !pending};

  // next state and result
  always_comb begin
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    ideal_nxt     = ideal_r;
    cpos_nxt      = cpos_r;
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    cur_bit_nxt   = cur_bit_r;
    res           = '0;

    if (pending) begin
      // one boundary step, rebasing time to the new segment
      elapsed_nxt = elapsed_sub;
      case (phase_r)
        PH_LEAD_MARK: begin
          phase_nxt = PH_LEAD_SPACE;
          ideal_nxt = TIME_WIDTH'(cfg.leader_space_us);
        end
        PH_BIT_MARK: begin
          phase_nxt = PH_BIT_SPACE;
          ideal_nxt = cur_bit_r ? TIME_WIDTH'(cfg.one_space_us) :
                                  TIME_WIDTH'(cfg.zero_space_us);
        end
        PH_LEAD_SPACE, PH_BIT_SPACE: begin
          if (bits_left_r != '0) begin
            cur_bit_nxt   = shift_r[0];
            shift_nxt     = shift_r >> 1;
            bits_left_nxt = bits_left_r - BITS_LEFT_W'(1);
            phase_nxt     = PH_BIT_MARK;
          end else begin
            phase_nxt = PH_FINAL_MARK;
          end
          ideal_nxt = TIME_WIDTH'(cfg.bit_mark_us);
          cpos_nxt  = '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (item.cmd == CMD_START) begin
        // start is taken only from idle
        if (phase_r == PH_IDLE) begin
          shift_nxt       = item.code_bits[MAX_CODE_BITS-1:0];
          bits_left_nxt   = BITS_LEFT_W'(len_sat);
          cur_bit_nxt     = 1'b0;
          phase_nxt       = PH_LEAD_MARK;
          elapsed_nxt     = '0;
          ideal_nxt       = TIME_WIDTH'(cfg.leader_mark_us);
          cpos_nxt        = '0;
          res.start_taken = 1'b1;
        end
        res.busy_res = 1'b1;
      end else if (phase_r != PH_IDLE) begin
        res.busy_res = 1'b1;
        if ((phase_r == PH_FINAL_MARK) && (cpos_r == '0) && time_up) begin
          // empty final mark ends the frame on this tick, dark
          elapsed_nxt    = elapsed_sub;
          phase_nxt      = PH_IDLE;
          res.frame_done = 1'b1;
        end else if (in_space) begin
          elapsed_nxt = elapsed_inc;
        end else if (in_mark) begin
          res.led     = (cpos_r < CPOS_W'(cfg.carrier_on_us));
          cpos_nxt    = (cpos_inc >= period) ? '0 : cpos_inc;
          elapsed_nxt = elapsed_inc;
          if ((phase_r == PH_FINAL_MARK) && (cpos_nxt == '0) &&
              (elapsed_inc >= ideal_r)) begin
            phase_nxt      = PH_IDLE;
            res.frame_done = 1'b1;
          end
        end
      end
    end
  end

endmodule

### hw/rtl/irpdt_out_buf.sv
// ----------------------------------------------------------------------------
// irpdt_out_buf
// Two-entry output register with skid slot driving the result channel.
// ----------------------------------------------------------------------------
module irpdt_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  irpdt_pkg::res_t    push_data,
  output logic               room,
  irpdt_out_if.source        out_ch
);
  import irpdt_pkg::*;

  logic main_valid_r, skid_valid_r;
  res_t main_r, skid_r;
  logic pop;

  assign pop  = main_valid_r && out_ch.ready;
  assign room = !skid_valid_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      main_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

  assign out_ch.valid       = main_valid_r;
  assign out_ch.led         = main_r.led;
  assign out_ch.busy_res    = main_r.busy_res;
  assign out_ch.start_taken = main_r.start_taken;
  assign out_ch.frame_done  = main_r.frame_done;

endmodule

### hw/rtl/ir_pulse_distance_transmitter_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_unit
// Infrared pulse-distance frame transmitter, one tick item per microsecond.
// ----------------------------------------------------------------------------
// Results: each result is registered in the output buffer before it is presented.
// Throughput: one item per cycle when the output buffer has room; each segment
// boundary holds the input while the sequencer crosses it, one boundary per
// cycle, so segments that are already over when they begin hold it as well.
// Reset: synchronous, active low; registers return to defaults, sequencer idle,
// output buffer empty.
module ir_pulse_distance_transmitter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  irpdt_in_if.sink                         in_ch,
  irpdt_out_if.source                      out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [irpdt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [irpdt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [irpdt_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import irpdt_pkg::*;

  cfg_t       cfg;
  item_t      item;
  res_t       res;
  core_stat_t core_stat;
  logic       room, accept;

  // configuration registers
  irpdt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input handshake
  assign in_ch.ready = core_stat.settled && room;
  assign accept      = in_ch.valid && in_ch.ready;
  assign item        = {in_ch.cmd, in_ch.code_bits, in_ch.code_length};

  // frame sequencer
  irpdt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (accept),
    .item   (item),
    .res    (res),
    .stat   (core_stat)
  );

  // result buffer
  irpdt_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .room      (room),
    .out_ch    (out_ch)
  );

  // frame end is only reported while busy and never on a start
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_done) |-> (out_ch.busy_res && !out_ch.start_taken))
    else $error("frame end reported without busy or on a start");

  // a taken start reports busy and a dark LED
  a_start_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.start_taken) |-> (out_ch.busy_res && !out_ch.led))
    else $error("taken start with LED lit or not busy");

  // a start transferred while idle leaves the sequencer busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.cmd == CMD_START) && !core_stat.busy) |=> core_stat.busy)
    else $error("start from idle did not begin a frame");

  // an idle sequencer never has a boundary to cross
  a_idle_settled: assert property (@(posedge clk) disable iff (!rst_n)
    !core_stat.busy |-> core_stat.settled)
    else $error("idle sequencer not settled");

endmodule

### test/ir_pulse_distance_transmitter_unit_test.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_unit_test
// Self-checking bench for the infrared pulse-distance transmitter. A driver
// feeds start and tick commands from a backlog queue. A predictor of the frame
// sequencer turns every transfer into the expected LED level and status flags.
// A monitor compares each result transfer with the oldest expectation. Timing
// registers are set over the APB port between phases and read back. The run
// covers reset timings, full-range timings, mark overrun and skipped segments,
// a carrier with no lit time, random timings, idle and stall patterns, and a
// long receiver hold-off.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import irpdt_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int FLUSH_CHUNK     = 8;
  localparam int RANDOM_PHASES   = 4;
  localparam int ITEMS_PER_PHASE = 150;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  irpdt_in_if  in_ch ();
  irpdt_out_if out_ch ();

  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ir_pulse_distance_transmitter_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // commands waiting to be sent, and frame results still to arrive
  item_t cmd_backlog[$];
  res_t  tick_result_q[$];

  // shadow of the timing registers and of the frame sequencer
  cfg_t                  timing;
  phase_t                seq_phase;
  logic [TIME_WIDTH-1:0] seg_elapsed;
  logic [TIME_WIDTH-1:0] seg_len;
  logic [CPOS_W-1:0]     carr_pos;
  logic [CODE_BITS_W-1:0] shift_bits;
  logic [CODE_LEN_W-1:0]  bits_remaining;
  logic                   bit_val;

  // idle and stall control
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_req     = 1'b0;
  int unsigned rx_hold_left;

  // bookkeeping
  int unsigned mismatches     = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned frames_begun   = 0;
  int unsigned frames_ended   = 0;
  int unsigned starts_refused = 0;
  int unsigned timing_sets    = 0;

  item_t acc_item;
  res_t  acc_res;
  item_t next_item;
  res_t  want_res;

  // advance the frame sequencer by one command and return the result it gives
  function automatic res_t step_transmitter(item_t it);
    res_t r;
    bit   is_mark;
    int   len;
    r = '0;
    if (it.cmd == CMD_START) begin
      if (seq_phase == PH_IDLE) begin
        len = int'(it.code_length);
        if (len > MAX_CODE_BITS) len = MAX_CODE_BITS;
        shift_bits     = it.code_bits;
        bits_remaining = CODE_LEN_W'(len);
        bit_val        = 1'b0;
        seq_phase      = PH_LEAD_MARK;
        seg_elapsed    = '0;
        seg_len        = TIME_WIDTH'(timing.leader_mark_us);
        carr_pos       = '0;
        r.start_taken  = 1'b1;
      end
      r.busy_res = (seq_phase != PH_IDLE);
      return r;
    end
    if (seq_phase == PH_IDLE) return r;

    // cross every segment boundary already reached
    forever begin
      is_mark = (seq_phase == PH_LEAD_MARK) || (seq_phase == PH_BIT_MARK) ||
                (seq_phase == PH_FINAL_MARK);
      if (seg_elapsed < seg_len || (is_mark && carr_pos != '0)) break;
      seg_elapsed = seg_elapsed - seg_len;
      case (seq_phase)
        PH_FINAL_MARK: begin
          // final mark with nothing left: frame ends on this tick, dark
          seq_phase    = PH_IDLE;
          r.busy_res   = 1'b1;
          r.frame_done = 1'b1;
          return r;
        end
        PH_LEAD_MARK: begin
          seq_phase = PH_LEAD_SPACE;
          seg_len   = TIME_WIDTH'(timing.leader_space_us);
        end
        PH_BIT_MARK: begin
          seq_phase = PH_BIT_SPACE;
          seg_len   = bit_val ? TIME_WIDTH'(timing.one_space_us)
                              : TIME_WIDTH'(timing.zero_space_us);
        end
        default: begin
          // end of a space: next bit mark, or the final mark
          if (bits_remaining != '0) begin
            bit_val        = shift_bits[0];
            shift_bits     = shift_bits >> 1;
            bits_remaining = bits_remaining - CODE_LEN_W'(1);
            seq_phase      = PH_BIT_MARK;
          end else begin
            seq_phase = PH_FINAL_MARK;
          end
          seg_len  = TIME_WIDTH'(timing.bit_mark_us);
          carr_pos = '0;
        end
      endcase
    end

    // spend the microsecond in the current segment
    if (seq_phase == PH_LEAD_SPACE || seq_phase == PH_BIT_SPACE) begin
      seg_elapsed = seg_elapsed + TIME_WIDTH'(1);
    end else begin
      r.led    = (carr_pos < CPOS_W'(timing.carrier_on_us));
      carr_pos = carr_pos + CPOS_W'(1);
      if (int'(carr_pos) >= int'(timing.carrier_on_us) + int'(timing.carrier_off_us))
        carr_pos = '0;
      seg_elapsed = seg_elapsed + TIME_WIDTH'(1);
      if (seq_phase == PH_FINAL_MARK && carr_pos == '0 && seg_elapsed >= seg_len) begin
        seq_phase    = PH_IDLE;
        r.busy_res   = 1'b1;
        r.frame_done = 1'b1;
        return r;
      end
    end
    r.busy_res = (seq_phase != PH_IDLE);
    return r;
  endfunction

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        acc_item = {in_ch.cmd, in_ch.code_bits, in_ch.code_length};
        acc_res  = step_transmitter(acc_item);
        tick_result_q.push_back(acc_res);
        items_sent++;
        if (acc_res.start_taken) frames_begun++;
        if (acc_item.cmd == CMD_START && !acc_res.start_taken) starts_refused++;
        if (acc_res.frame_done) frames_ended++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_item = cmd_backlog.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.cmd         <= next_item.cmd;
          in_ch.code_bits   <= next_item.code_bits;
          in_ch.code_length <= next_item.code_length;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
    end else if (hold_req && rx_hold_left == 0) begin
      rx_hold_left <= HOLD_OFF_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (tick_result_q.size() == 0) begin
          $display("%0t: result transfer with none outstanding, expected none, actual %b",
                   $time, {out_ch.led, out_ch.busy_res, out_ch.start_taken,
                           out_ch.frame_done});
          mismatches++;
        end else begin
          want_res = tick_result_q.pop_front();
          check_field("led", want_res.led, out_ch.led);
          check_field("busy_res", want_res.busy_res, out_ch.busy_res);
          check_field("start_taken", want_res.start_taken, out_ch.start_taken);
          check_field("frame_done", want_res.frame_done, out_ch.frame_done);
          results_seen++;
        end
      end
      out_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic void queue_item(logic cmd, logic [CODE_BITS_W-1:0] bits,
                                     logic [CODE_LEN_W-1:0] len);
    item_t it;
    it.cmd         = cmd;
    it.code_bits   = bits;
    it.code_length = len;
    cmd_backlog.push_back(it);
  endfunction

  // ticks carry random code fields, which the block must ignore
  function automatic void queue_ticks(int n);
    for (int i = 0; i < n; i++)
      queue_item(CMD_TICK, {$urandom(), $urandom()}, CODE_LEN_W'($urandom_range(127)));
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_ch.valid || tick_result_q.size() != 0);
  endtask

  // drain the channels and tick any running frame to its end
  task automatic settle();
    wait_drained();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    while (seq_phase != PH_IDLE) begin
      queue_ticks(FLUSH_CHUNK);
      wait_drained();
    end
    repeat (3) @(negedge clk);
  endtask

  // read every register and compare with the shadow
  task automatic check_regs();
    logic [CFG_DATA_W-1:0] want [7];
    logic [CFG_DATA_W-1:0] got;
    want[REG_LEADER_MARK]  = CFG_DATA_W'(timing.leader_mark_us);
    want[REG_LEADER_SPACE] = CFG_DATA_W'(timing.leader_space_us);
    want[REG_BIT_MARK]     = CFG_DATA_W'(timing.bit_mark_us);
    want[REG_ZERO_SPACE]   = CFG_DATA_W'(timing.zero_space_us);
    want[REG_ONE_SPACE]    = CFG_DATA_W'(timing.one_space_us);
    want[REG_CARRIER_ON]   = CFG_DATA_W'(timing.carrier_on_us);
    want[REG_CARRIER_OFF]  = CFG_DATA_W'(timing.carrier_off_us);
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      cfg_paddr   <= CFG_ADDR_W'(i * 4);
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      got = cfg_prdata;
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      if (got !== want[i]) begin
        $display("%0t: register %0d read back, expected %0h, actual %0h",
                 $time, i, want[i], got);
        mismatches++;
      end
    end
    @(negedge clk);
  endtask

  // write all timing registers, then read them back
  task automatic apply_timing(int unsigned lm, int unsigned ls, int unsigned bm,
                              int unsigned zs, int unsigned os, int unsigned con,
                              int unsigned coff);
    logic [CFG_DATA_W-1:0] vals [7];
    vals[REG_LEADER_MARK]  = lm;
    vals[REG_LEADER_SPACE] = ls;
    vals[REG_BIT_MARK]     = bm;
    vals[REG_ZERO_SPACE]   = zs;
    vals[REG_ONE_SPACE]    = os;
    vals[REG_CARRIER_ON]   = con;
    vals[REG_CARRIER_OFF]  = coff;
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= CFG_ADDR_W'(i * 4);
      cfg_pwdata  <= vals[i];
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
    end
    timing.leader_mark_us  = SEG_W'(lm);
    timing.leader_space_us = SEG_W'(ls);
    timing.bit_mark_us     = SEG_W'(bm);
    timing.zero_space_us   = SEG_W'(zs);
    timing.one_space_us    = SEG_W'(os);
    timing.carrier_on_us   = CARR_W'(con);
    timing.carrier_off_us  = CARR_W'(coff);
    timing_sets++;
    @(negedge clk);
    check_regs();
  endtask

  // short values, at the minimum one time in four
  function automatic int unsigned pick_len(int unsigned lo, int unsigned hi);
    return ($urandom_range(3) == 0) ? lo : $urandom_range(hi, lo);
  endfunction

  // stimulus
  initial begin
    int unsigned sel;
    int unsigned len;

    // known levels from time zero
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_TICK;
    in_ch.code_bits   = '0;
    in_ch.code_length = '0;
    out_ch.ready      = 1'b0;
    timing = {RST_LEADER_MARK, RST_LEADER_SPACE, RST_BIT_MARK, RST_ZERO_SPACE,
              RST_ONE_SPACE, RST_CARRIER_ON, RST_CARRIER_OFF};
    seq_phase      = PH_IDLE;
    seg_elapsed    = '0;
    seg_len        = '0;
    carr_pos       = '0;
    shift_bits     = '0;
    bits_remaining = '0;
    bit_val        = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_regs();

    // reset timings: a tick while idle
    queue_ticks(1);
    settle();

    // short timings: empty frame, start refused while busy, oversized length
    // saturates, all-zero and all-one codes
    apply_timing(3, 2, 2, 0, 1, 1, 1);
    queue_item(CMD_START, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    queue_item(CMD_START, 64'h0000_0000_0000_0001, 7'd127);
    queue_ticks(3);
    settle();
    queue_item(CMD_START, 64'hA5A5_5A5A_F00F_0FF0, 7'd127);
    settle();
    queue_item(CMD_START, 64'h0, 7'd16);
    settle();
    queue_item(CMD_START, 64'hFFFF_FFFF_FFFF_FFFF, 7'd16);
    settle();

    // long carrier against short marks: overrun, skipped spaces, empty final mark
    apply_timing(1, 0, 1, 0, 3, 5, 6);
    queue_item(CMD_START, 64'h5, 7'd3);
    settle();
    queue_item(CMD_START, 64'h0, 7'd0);
    settle();

    // carrier with no lit and no dark time
    apply_timing(3, 2, 2, 1, 2, 0, 0);
    queue_item(CMD_START, 64'h2, 7'd2);
    settle();

    // full-range register values, read back only
    apply_timing(65535, 65535, 65535, 65535, 65535, 127, 127);

    // widest lit time against short marks: every later segment is skipped
    apply_timing(1, 0, 1, 0, 0, 127, 1);
    queue_item(CMD_START, 64'h1F, 7'd5);
    settle();

    // random timings under each idle pattern
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_timing(pick_len(1, 8), pick_len(0, 6), pick_len(1, 4), pick_len(0, 3),
                   pick_len(0, 6), pick_len(1, 3), pick_len(1, 3));
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      if (ph == 0) begin
        // receiver holds off while the sender keeps offering
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        @(negedge clk);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(11) == 0) begin
          sel = $urandom_range(99);
          if (sel < 60)      len = $urandom_range(8);
          else if (sel < 85) len = $urandom_range(64, 9);
          else               len = $urandom_range(127, 65);
          queue_item(CMD_START, {$urandom(), $urandom()}, CODE_LEN_W'(len));
        end else begin
          queue_ticks(1);
        end
      end
      settle();
    end

    wait_drained();
    repeat (4) @(negedge clk);
    $display("run covered %0d command transfers and %0d result transfers over %0d timing sets",
             items_sent, results_seen, timing_sets);
    $display("frames: %0d begun, %0d completed, %0d starts refused while busy",
             frames_begun, frames_ended, starts_refused);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("timeout with %0d results outstanding", tick_result_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
hw/rtl/irpdt_pkg.sv
hw/rtl/irpdt_ifs.sv
hw/rtl/irpdt_cfg_regs.sv
hw/rtl/irpdt_core.sv
hw/rtl/irpdt_out_buf.sv
hw/rtl/ir_pulse_distance_transmitter_unit.sv
test/ir_pulse_distance_transmitter_unit_test.sv
